@@ rtl/rieu_pkg.sv @@
// package: payload structs, opcodes and constants for the integer execute unit
`timescale 1ns / 1ps
package rieu_pkg;

  localparam int NUM_REGISTERS = 32;
  localparam int REG_IDX_W = $clog2(NUM_REGISTERS);

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_SYSCALL = 3'd2;
  localparam logic [2:0] ST_FAULT   = 3'd3;
  localparam logic [2:0] ST_NO_LOAD = 3'd4;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic [2:0] LK_LB  = 3'd0;
  localparam logic [2:0] LK_LH  = 3'd1;
  localparam logic [2:0] LK_LW  = 3'd2;
  localparam logic [2:0] LK_LBU = 3'd3;
  localparam logic [2:0] LK_LHU = 3'd4;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  // opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // special funct codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_SYS   = 6'h0c;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1a;
  localparam logic [5:0] FN_DIVU  = 6'h1b;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2a;
  localparam logic [5:0] FN_SLTU  = 6'h2b;

  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  localparam logic [4:0] REG_RA = 5'd31;
  localparam logic [4:0] REG_V0 = 5'd2;

  // shared alu operations
  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_NOR,
    ALU_SLT, ALU_SLTU, ALU_SLL, ALU_SRL, ALU_SRA, ALU_PASS_B
  } alu_op_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] instruction_word;
    logic [31:0] load_data;
    logic        load_fault;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic [31:0] store_value;
    logic        wb_valid;
    logic [4:0]  wb_index;
    logic [31:0] wb_value;
    logic [31:0] syscall_code;
  } out_item_t;

  // multiply/divide request and result
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic        sgn;
  } md_ctrl_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_stat_t;

endpackage

@@ rtl/rieu_alu.sv @@
// shared alu: add, subtract, logic, compares and shifts
`timescale 1ns / 1ps
module rieu_alu import rieu_pkg::*; (
  input  alu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [4:0]  sh,
  output logic [31:0] y
);
  logic [32:0] diff;
  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    unique case (op)
      ALU_ADD:    y = a + b;
      ALU_SUB:    y = diff[31:0];
      ALU_AND:    y = a & b;
      ALU_OR:     y = a | b;
      ALU_XOR:    y = a ^ b;
      ALU_NOR:    y = ~(a | b);
      ALU_SLT:    y = {31'd0, $signed(a) < $signed(b)};
      ALU_SLTU:   y = {31'd0, diff[32]};
      ALU_SLL:    y = b << sh;
      ALU_SRL:    y = b >> sh;
      ALU_SRA:    y = 32'($signed(b) >>> sh);
      ALU_PASS_B: y = b;
      default:    y = b;
    endcase
  end
endmodule

@@ rtl/rieu_muldiv.sv @@
// iterative multiply/divide unit, one bit per cycle
`timescale 1ns / 1ps
module rieu_muldiv import rieu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  md_ctrl_t    ctrl,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output md_stat_t    stat
);
  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        is_div_r, is_div_nxt;
  logic        neg_q_r, neg_q_nxt, neg_r_r, neg_r_nxt;
  logic        zero_r, zero_nxt;
  logic [31:0] orig_a_r, orig_a_nxt;
  logic [31:0] acc_r, acc_nxt;   // multiply: high product; divide: remainder
  logic [31:0] q_r, q_nxt;       // multiply: multiplier/low product; divide: quotient
  logic [31:0] d_r, d_nxt;       // multiplicand or divisor magnitude
  logic        done_r, done_nxt;
  logic [31:0] ma, mb;
  logic [32:0] sum, trial;
  logic [63:0] prod;

  assign ma = (ctrl.sgn && a[31]) ? 32'd0 - a : a;
  assign mb = (ctrl.sgn && b[31]) ? 32'd0 - b : b;
  assign sum = {1'b0, acc_r} + (q_r[0] ? {1'b0, d_r} : 33'd0);
  assign trial = {acc_r, q_r[31]} - {1'b0, d_r};
  assign prod = {acc_r, q_r};

  always_comb begin
    busy_nxt = busy_r; cnt_nxt = cnt_r; is_div_nxt = is_div_r;
    neg_q_nxt = neg_q_r; neg_r_nxt = neg_r_r; zero_nxt = zero_r;
    orig_a_nxt = orig_a_r; acc_nxt = acc_r; q_nxt = q_r; d_nxt = d_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      busy_nxt = 1'b1; cnt_nxt = 6'd32; is_div_nxt = ctrl.is_div;
      orig_a_nxt = a; zero_nxt = (b == 32'd0);
      acc_nxt = 32'd0; q_nxt = ma; d_nxt = mb;
      neg_r_nxt = ctrl.sgn && a[31];
      neg_q_nxt = ctrl.sgn && (a[31] ^ b[31]);
    end else if (busy_r) begin
      if (is_div_r) begin
        if (!trial[32]) begin
          acc_nxt = trial[31:0]; q_nxt = {q_r[30:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[30:0], q_r[31]}; q_nxt = {q_r[30:0], 1'b0};
        end
      end else begin
        acc_nxt = sum[32:1]; q_nxt = {sum[0], q_r[31:1]};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= 6'd0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    is_div_r <= is_div_nxt; neg_q_r <= neg_q_nxt; neg_r_r <= neg_r_nxt;
    zero_r <= zero_nxt; orig_a_r <= orig_a_nxt;
    acc_r <= acc_nxt; q_r <= q_nxt; d_r <= d_nxt;
  end

  // sign fixup on the final registered value
  logic [63:0] sprod;
  assign sprod = neg_q_r ? 64'd0 - prod : prod;

  always_comb begin
    stat.done = done_r;
    if (is_div_r) begin
      if (zero_r) begin
        stat.lo = ALL_ONES; stat.hi = orig_a_r;
      end else begin
        stat.lo = neg_q_r ? 32'd0 - q_r : q_r;
        stat.hi = neg_r_r ? 32'd0 - acc_r : acc_r;
      end
    end else begin
      stat.hi = sprod[63:32]; stat.lo = sprod[31:0];
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) ctrl.start |=> busy_r)
    else $error("muldiv did not start");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("muldiv done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> !ctrl.start)
    else $error("muldiv restarted while busy");
endmodule

@@ rtl/risc_integer_execute_unit_top.sv @@
// top level: sequencer, register file, hi/lo, pc and result register
// sequence: ordinary items pass through accept, read, execute and write/result states;
//   mult/div items also wait in S_MD on the 32-step shift-add/subtract unit
// throughput: one item at a time; next item accepted once the result is taken
// reset: synchronous active-low rst_n clears control, registers, hi/lo and pc
//   with no clearing pass (register file uses per-entry valid bits)
`timescale 1ns / 1ps
module risc_integer_execute_unit_top import rieu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_READ = 5'b00010, S_EXEC = 5'b00100,
    S_MD = 5'b01000, S_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] rf_mem [NUM_REGISTERS];
  logic [NUM_REGISTERS-1:0] rf_vld_r;
  logic [31:0] ra_r, rb_r, rv0_r;
  logic [31:0] hi_r, lo_r, pc_r;
  logic        lp_r;
  logic [4:0]  lt_r;
  logic [2:0]  lk_r;
  in_item_t    item_r;
  out_item_t   res_r, res_nxt;

  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, zimm, pc4, btarget, jtarget;

  assign op = item_r.instruction_word[31:26];
  assign rs = item_r.instruction_word[25:21];
  assign rt = item_r.instruction_word[20:16];
  assign rd = item_r.instruction_word[15:11];
  assign sh = item_r.instruction_word[10:6];
  assign fn = item_r.instruction_word[5:0];
  assign imm = item_r.instruction_word[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign zimm = {16'd0, imm};
  assign pc4 = pc_r + 32'd4;
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign jtarget = {pc4[31:28], item_r.instruction_word[25:0], 2'b00};

  // alu
  alu_op_t     alu_op;
  logic [31:0] alu_a, alu_b, alu_y;
  logic [4:0]  alu_sh;
  rieu_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .sh(alu_sh), .y(alu_y));

  // multiply/divide
  md_ctrl_t md_ctrl;
  md_stat_t md_stat;
  rieu_muldiv u_md (.clk(clk), .rst_n(rst_n), .ctrl(md_ctrl), .a(ra_r), .b(rb_r),
    .stat(md_stat));

  // decode
  logic        illegal, wr_en, is_md, take, wr_hi, wr_lo, start_load, is_sys;
  logic [4:0]  wr_idx;
  logic [31:0] wr_val, npc;
  logic [2:0]  new_lk;

  always_comb begin
    illegal = 1'b0; wr_en = 1'b0; wr_idx = rd; wr_val = alu_y;
    is_md = 1'b0; take = 1'b0; wr_hi = 1'b0; wr_lo = 1'b0;
    start_load = 1'b0; is_sys = 1'b0; new_lk = LK_LB;
    alu_op = ALU_ADD; alu_a = ra_r; alu_b = rb_r; alu_sh = sh;
    md_ctrl = '0;
    npc = pc4;
    res_nxt = '0;
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_SLL:  begin alu_op = ALU_SLL; wr_en = 1'b1; end
          FN_SRL:  begin alu_op = ALU_SRL; wr_en = 1'b1; end
          FN_SRA:  begin alu_op = ALU_SRA; wr_en = 1'b1; end
          FN_SLLV: begin alu_op = ALU_SLL; alu_sh = ra_r[4:0]; wr_en = 1'b1; end
          FN_SRLV: begin alu_op = ALU_SRL; alu_sh = ra_r[4:0]; wr_en = 1'b1; end
          FN_SRAV: begin alu_op = ALU_SRA; alu_sh = ra_r[4:0]; wr_en = 1'b1; end
          FN_JR:   npc = ra_r;
          FN_JALR: begin npc = ra_r; wr_en = 1'b1; wr_val = pc4; end
          FN_SYS:  is_sys = 1'b1;
          FN_MFHI: begin wr_en = 1'b1; wr_val = hi_r; end
          FN_MTHI: wr_hi = 1'b1;
          FN_MFLO: begin wr_en = 1'b1; wr_val = lo_r; end
          FN_MTLO: wr_lo = 1'b1;
          FN_MULT:  begin is_md = 1'b1; md_ctrl.sgn = 1'b1; end
          FN_MULTU: is_md = 1'b1;
          FN_DIV:   begin is_md = 1'b1; md_ctrl.sgn = 1'b1; md_ctrl.is_div = 1'b1; end
          FN_DIVU:  begin is_md = 1'b1; md_ctrl.is_div = 1'b1; end
          FN_ADD, FN_ADDU: begin alu_op = ALU_ADD; wr_en = 1'b1; end
          FN_SUB, FN_SUBU: begin alu_op = ALU_SUB; wr_en = 1'b1; end
          FN_AND:  begin alu_op = ALU_AND; wr_en = 1'b1; end
          FN_OR:   begin alu_op = ALU_OR; wr_en = 1'b1; end
          FN_XOR:  begin alu_op = ALU_XOR; wr_en = 1'b1; end
          FN_NOR:  begin alu_op = ALU_NOR; wr_en = 1'b1; end
          FN_SLT:  begin alu_op = ALU_SLT; wr_en = 1'b1; end
          FN_SLTU: begin alu_op = ALU_SLTU; wr_en = 1'b1; end
          default: illegal = 1'b1;
        endcase
      end
      OP_REGIMM: begin
        if (rt != RI_BLTZ && rt != RI_BGEZ && rt != RI_BLTZAL && rt != RI_BGEZAL) begin
          illegal = 1'b1;
        end else begin
          take = rt[0] ? !ra_r[31] : ra_r[31];
          if (rt[4]) begin
            wr_en = 1'b1; wr_idx = REG_RA; wr_val = pc4;
          end
        end
      end
      OP_J:   npc = jtarget;
      OP_JAL: begin npc = jtarget; wr_en = 1'b1; wr_idx = REG_RA; wr_val = pc4; end
      OP_BEQ:  begin alu_op = ALU_SUB; take = (alu_y == 32'd0); end
      OP_BNE:  begin alu_op = ALU_SUB; take = (alu_y != 32'd0); end
      OP_BLEZ: take = (ra_r == 32'd0) || ra_r[31];
      OP_BGTZ: take = (ra_r != 32'd0) && !ra_r[31];
      OP_ADDI, OP_ADDIU: begin alu_b = simm; wr_en = 1'b1; wr_idx = rt; end
      OP_SLTI:  begin alu_op = ALU_SLT; alu_b = simm; wr_en = 1'b1; wr_idx = rt; end
      OP_SLTIU: begin alu_op = ALU_SLTU; alu_b = simm; wr_en = 1'b1; wr_idx = rt; end
      OP_ANDI:  begin alu_op = ALU_AND; alu_b = zimm; wr_en = 1'b1; wr_idx = rt; end
      OP_ORI:   begin alu_op = ALU_OR; alu_b = zimm; wr_en = 1'b1; wr_idx = rt; end
      OP_XORI:  begin alu_op = ALU_XOR; alu_b = zimm; wr_en = 1'b1; wr_idx = rt; end
      OP_LUI:   begin
        alu_op = ALU_SLL; alu_b = zimm; alu_sh = 5'd16; wr_en = 1'b1; wr_idx = rt;
      end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        alu_b = simm; start_load = 1'b1;
        res_nxt.mem_op = MEM_LOAD; res_nxt.mem_addr = alu_y;
        priority case (op)
          OP_LB:   new_lk = LK_LB;
          OP_LH:   new_lk = LK_LH;
          OP_LW:   new_lk = LK_LW;
          OP_LBU:  new_lk = LK_LBU;
          default: new_lk = LK_LHU;
        endcase
        res_nxt.mem_size = (new_lk == LK_LW) ? SZ_WORD :
          (new_lk == LK_LH || new_lk == LK_LHU) ? SZ_HALF : SZ_BYTE;
      end
      OP_SB, OP_SH, OP_SW: begin
        alu_b = simm;
        res_nxt.mem_op = MEM_STORE; res_nxt.mem_addr = alu_y;
        priority case (op)
          OP_SB: begin res_nxt.mem_size = SZ_BYTE; res_nxt.store_value = {24'd0, rb_r[7:0]}; end
          OP_SH: begin res_nxt.mem_size = SZ_HALF; res_nxt.store_value = {16'd0, rb_r[15:0]}; end
          default: begin res_nxt.mem_size = SZ_WORD; res_nxt.store_value = rb_r; end
        endcase
      end
      default: illegal = 1'b1;
    endcase
    if (take) npc = btarget;
    if (illegal) begin
      npc = pc_r; wr_en = 1'b0; wr_hi = 1'b0; wr_lo = 1'b0; is_md = 1'b0;
      start_load = 1'b0; res_nxt = '0; res_nxt.status = ST_ILLEGAL;
    end
    if (is_sys) begin
      res_nxt.status = ST_SYSCALL; res_nxt.syscall_code = rv0_r;
    end
    if (wr_en && wr_idx != 5'd0) begin
      res_nxt.wb_valid = 1'b1; res_nxt.wb_index = wr_idx; res_nxt.wb_value = wr_val;
    end
    res_nxt.next_pc = npc;
    // a load return carries no instruction, so it never starts the unit
    md_ctrl.start = is_md && !item_r.mode && (state_r == S_EXEC);
  end

  // load return path
  logic [31:0] ld_val;
  out_item_t   ld_res;
  always_comb begin
    unique case (lk_r)
      LK_LB:   ld_val = {{24{item_r.load_data[7]}}, item_r.load_data[7:0]};
      LK_LH:   ld_val = {{16{item_r.load_data[15]}}, item_r.load_data[15:0]};
      LK_LBU:  ld_val = {24'd0, item_r.load_data[7:0]};
      LK_LHU:  ld_val = {16'd0, item_r.load_data[15:0]};
      default: ld_val = item_r.load_data;
    endcase
  end

  always_comb begin
    ld_res = '0;
    ld_res.next_pc = pc_r;
    if (!lp_r) begin
      ld_res.status = ST_NO_LOAD;
    end else if (item_r.load_fault) begin
      ld_res.status = ST_FAULT;
    end else if (lt_r != 5'd0) begin
      ld_res.wb_valid = 1'b1; ld_res.wb_index = lt_r; ld_res.wb_value = ld_val;
    end
  end

  logic in_xfer, out_xfer;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_xfer = out_valid && out_ready;
  assign out_data = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = (!item_r.mode && is_md) ? S_MD : S_OUT;
      S_MD:   if (md_stat.done) state_nxt = S_OUT;
      S_OUT:  if (out_xfer) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // register file reads registered, invalid entries read as zero
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_xfer) item_r <= in_data;
    if (state_r == S_READ) begin
      ra_r  <= rf_vld_r[rs] ? rf_mem[rs] : 32'd0;
      rb_r  <= rf_vld_r[rt] ? rf_mem[rt] : 32'd0;
      rv0_r <= rf_vld_r[REG_V0] ? rf_mem[REG_V0] : 32'd0;
    end
    if (state_r == S_EXEC) begin
      if (!item_r.mode) begin
        if (wr_en && !illegal && wr_idx != 5'd0) rf_mem[wr_idx] <= wr_val;
      end else if (lp_r && !item_r.load_fault && lt_r != 5'd0) begin
        rf_mem[lt_r] <= ld_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; rf_vld_r <= '0; hi_r <= '0; lo_r <= '0; pc_r <= '0;
      lp_r <= 1'b0; lt_r <= '0; lk_r <= LK_LB; res_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) pc_r <= cfg_wdata;
      if (state_r == S_EXEC) begin
        if (!item_r.mode) begin
          res_r <= res_nxt;
          lp_r <= start_load;
          if (start_load) begin lt_r <= rt; lk_r <= new_lk; end
          if (!illegal) pc_r <= npc;
          if (wr_en && !illegal && wr_idx != 5'd0) rf_vld_r[wr_idx] <= 1'b1;
          if (wr_hi && !illegal) hi_r <= ra_r;
          if (wr_lo && !illegal) lo_r <= ra_r;
        end else begin
          res_r <= ld_res;
          if (lp_r) begin
            lp_r <= 1'b0;
            if (!item_r.load_fault && lt_r != 5'd0) rf_vld_r[lt_r] <= 1'b1;
          end
        end
      end
      if (state_r == S_MD && md_stat.done) begin
        hi_r <= md_stat.hi; lo_r <= md_stat.lo;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> state_r == S_READ)
    else $error("accepted transfer did not start read");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("input ready while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    md_stat.done |-> state_r == S_MD)
    else $error("muldiv finished outside wait state");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.wb_valid || out_data.wb_index != 5'd0))
    else $error("register zero reported as written");
endmodule
